// ===== sv/iom_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Interval overlap maximum: shared types and constants
// Request and response payloads, command codes and count limits.
// ----------------------------------------------------------------------------
package iom_pkg;

  localparam int START_W = 10;
  localparam int END_W   = 11;
  localparam int CNT_W   = 11;

  // Coverage and interval counts saturate at the top of their field.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [START_W-1:0] start_slot;
    logic [END_W-1:0]   end_slot;
  } in_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] interval_total;
    logic [CNT_W-1:0] peak_overlap;
    logic             dropped_some;
  } out_rsp_t;

endpackage : iom_pkg
`default_nettype wire

// ===== sv/iom_cov_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Interval overlap maximum: slot coverage memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iom_cov_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int W     = 11
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [W-1:0]  wr_data,
  output logic      [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  // A read and a write to the same address in one cycle returns the old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : iom_cov_mem
`default_nettype wire

// ===== sv/interval_overlap_max.sv =====
`default_nettype none
// An add request enters the add state, which reads each slot from start_slot up
// to but not including min(end_slot, SLOTS), then returns to idle; a dropped add
// stays in idle. A finish request reads and clears every slot, then the response
// becomes valid. Requests are taken one at a time; in_ready is high only in idle.
// Reset is synchronous, active low, and starts a clearing sweep over every slot
// of the coverage memory, during which in_ready stays low.
// ----------------------------------------------------------------------------
// Interval overlap maximum: top level
// Counts per-slot coverage of half-open intervals and reports the peak.
// ----------------------------------------------------------------------------
module interval_overlap_max #(
  parameter int SLOTS         = 1024,
  parameter int MAX_INTERVALS = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire iom_pkg::in_req_t in_req,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output iom_pkg::out_rsp_t    out_rsp
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // The slot walker must hold SLOTS itself and the full end_slot field.
  localparam int PW = ((AW + 1) > iom_pkg::END_W) ? (AW + 1) : iom_pkg::END_W;
  localparam logic [PW-1:0] SLOTS_W    = PW'(SLOTS);
  localparam logic [PW-1:0] SLOTS_LAST = PW'(SLOTS - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ADD    = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [PW-1:0]               slot_r, slot_nxt;
  logic [PW-1:0]               hi_r, hi_nxt;
  logic [iom_pkg::CNT_W-1:0]   acc_r, acc_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [iom_pkg::CNT_W-1:0]   peak_r, peak_nxt;
  logic                        wb_r, wb_nxt;
  logic                        pk_r, pk_nxt;
  logic [AW-1:0]               rd_addr_r;

  logic                        mem_rd_en;
  logic                        mem_wr_en;
  logic [AW-1:0]               mem_wr_addr;
  logic [iom_pkg::CNT_W-1:0]   mem_wr_data;
  logic [iom_pkg::CNT_W-1:0]   mem_rd_data;
  logic [PW-1:0]               end_ext;

  // All coverage traffic goes through one memory. During an add, the slot read
  // in one cycle is written back incremented in the next, so consecutive slots
  // overlap their read and write phases and no address is touched twice in flight.
  iom_cov_mem #(
    .DEPTH (SLOTS),
    .AW    (AW),
    .W     (iom_pkg::CNT_W)
  ) u_cov_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (slot_r[AW-1:0]),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_REPORT);

  assign out_rsp.interval_total = acc_r;
  assign out_rsp.peak_overlap   = peak_r;
  assign out_rsp.dropped_some   = ovf_r;

  assign end_ext = PW'(in_req.end_slot);

  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    hi_nxt      = hi_r;
    acc_nxt     = acc_r;
    ovf_nxt     = ovf_r;
    peak_nxt    = peak_r;
    wb_nxt      = 1'b0;
    pk_nxt      = 1'b0;
    mem_rd_en   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = rd_addr_r;
    mem_wr_data = '0;

    // Write-back stage of an add: saturating increment of the slot just read.
    if (wb_r) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = rd_addr_r;
      mem_wr_data = (mem_rd_data == iom_pkg::CNT_MAX) ? mem_rd_data
                                                      : mem_rd_data + 1'b1;
    end

    // Compare stage of a finish scan.
    if (pk_r && (mem_rd_data > peak_r)) begin
      peak_nxt = mem_rd_data;
    end

    case (state_r)
      ST_CLEAR: begin
        // Post-reset sweep: zero one slot per cycle.
        mem_wr_en   = 1'b1;
        mem_wr_addr = slot_r[AW-1:0];
        mem_wr_data = '0;
        if (slot_r == SLOTS_LAST) begin
          slot_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req.cmd == iom_pkg::CMD_FINISH) begin
            slot_nxt  = '0;
            peak_nxt  = '0;
            state_nxt = ST_SCAN;
          end else if (int'(acc_r) >= MAX_INTERVALS) begin
            // Capacity reached: the interval is dropped and flagged.
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt   = (acc_r == iom_pkg::CNT_MAX) ? acc_r : acc_r + 1'b1;
            slot_nxt  = PW'(in_req.start_slot);
            // Slots past the end of the time line are ignored.
            hi_nxt    = (end_ext > SLOTS_W) ? SLOTS_W : end_ext;
            state_nxt = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        // Empty or fully clipped intervals read no slot and return to idle.
        if (slot_r < hi_r) begin
          mem_rd_en = 1'b1;
          wb_nxt    = 1'b1;
          slot_nxt  = slot_r + 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Read every slot for the peak and clear it in the same cycle; the
        // memory returns the value from before the clearing write.
        if (slot_r < SLOTS_W) begin
          mem_rd_en   = 1'b1;
          mem_wr_en   = 1'b1;
          mem_wr_addr = slot_r[AW-1:0];
          mem_wr_data = '0;
          pk_nxt      = 1'b1;
          slot_nxt    = slot_r + 1'b1;
        end else begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        // The count and the overflow flag restart once the response is taken.
        if (out_ready) begin
          acc_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      slot_r  <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      wb_r    <= 1'b0;
      pk_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      wb_r    <= wb_nxt;
      pk_r    <= pk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r   <= hi_nxt;
    peak_r <= peak_nxt;
    if (mem_rd_en) begin
      rd_addr_r <= slot_r[AW-1:0];
    end
  end

endmodule : interval_overlap_max
`default_nettype wire
